[hw/rtl/c1dtf_pkg.sv]
// Shared constants, types and helpers for the 1-D text convolution block.
// No dependencies; imported by c1dtf_wmem and conv1d_text_forward.
`timescale 1ns / 1ps
`default_nettype none

package c1dtf_pkg;

  // Kernel geometry and sentence limits
  localparam int unsigned TAPS     = 5;
  localparam int unsigned MAX_DIM  = 512;
  localparam int unsigned MAX_ROWS = 1024;

  // Field and datapath widths
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned TAP_W   = 3;
  localparam int unsigned WELEM_W = 9;
  localparam int unsigned DIM_W   = 10;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned BIAS_W  = 32;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned FRAC    = 12;
  localparam int unsigned PROD_W  = 2 * VAL_W;
  localparam int unsigned ELEM_W  = $clog2(MAX_DIM);
  localparam int unsigned ROW_W   = $clog2(MAX_ROWS);
  localparam int unsigned SLOT_W  = (TAPS > 1) ? $clog2(TAPS) : 1;

  // Configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_LOAD   = 1'b1
  } action_e;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_BIAS      = 1'b0,
    REG_EMBED_DIM = 1'b1
  } reg_e;

  // One weight per tap, all at the same element position
  typedef logic [TAPS-1:0][VAL_W-1:0] wvec_t;

  // Weight write request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] bank;
    logic [ELEM_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } wr_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic              emit;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] fill;
  } ctrl_t;

  // (a - b) modulo TAPS for a, b below TAPS
  function automatic logic [SLOT_W-1:0] ring_slot(logic [SLOT_W-1:0] a,
                                                  logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] t;
    t = (SLOT_W+1)'(a) + (SLOT_W+1)'(TAPS) - (SLOT_W+1)'(b);
    if (t >= (SLOT_W+1)'(TAPS)) begin
      t = t - (SLOT_W+1)'(TAPS);
    end
    return SLOT_W'(t);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/c1dtf_wmem.sv]
// Kernel weight store: one bank per tap, one write and one read port each.
// Depends on c1dtf_pkg for geometry and the write request type.
`timescale 1ns / 1ps
`default_nettype none

module c1dtf_wmem
  import c1dtf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire wr_t               wr_i,
  input  wire logic              rd_en_i,
  input  wire logic [ELEM_W-1:0] rd_addr_i,
  output wvec_t                  rd_data_o
);

  // One bank per tap, all read at the same element position
  for (genvar b = 0; b < TAPS; b++) begin : g_bank
    logic [VAL_W-1:0] mem [MAX_DIM];
    logic [VAL_W-1:0] rd_q;

    // Write the addressed bank only
    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.bank == SLOT_W'(b))) begin
        mem[wr_i.addr] <= wr_i.data;
      end
    end

    // Registered read; hold while the consumer stalls
    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        rd_q <= mem[rd_addr_i];
      end
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule

`default_nettype wire

[hw/rtl/conv1d_text_forward.sv]
// Streaming valid 1-D convolution over embedding rows, top level.
// Depends on c1dtf_pkg and c1dtf_wmem (per-tap weight banks).
//
//  channel | direction | handshake                | beat
//  --------+-----------+--------------------------+-------------------------------------
//  in      | sink      | in_valid_i / in_ready_o  | action, value, weight_tap/elem, end
//  out     | source    | out_valid_o / out_ready_i| out_value, out_index, last
//  cfg     | APB slave | psel, penable, pready=1  | bias @0x0, embed_dim @0x4
//
// One beat accepted per cycle while in_ready_o is high. A sample's path to its result runs:
// weight read, per-tap multiply, accumulate, then shift/bias/saturate into the
// output register. The pipeline advances stage by stage, so a bubble is filled
// while a result waits; in_ready_o drops only when every stage is occupied.
// Reset clears counters, accumulators, valids and bias; data and weights stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module conv1d_text_forward
  import c1dtf_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // input beats
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     action_i,
  input  wire logic signed [VAL_W-1:0]  value_i,
  input  wire logic [TAP_W-1:0]         weight_tap_i,
  input  wire logic [WELEM_W-1:0]       weight_elem_i,
  input  wire logic                     sentence_end_i,
  // result beats
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [OUT_W-1:0]       out_value_o,
  output logic [IDX_W-1:0]              out_index_o,
  output logic                          last_o,
  // configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers (register picked by paddr[2])
  // ---------------------------------------------------------------------------
  logic signed [BIAS_W-1:0] bias_q;
  logic [DIM_W-1:0]         embed_dim_q;
  reg_e                     reg_sel;
  logic                     cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q      <= '0;
      embed_dim_q <= DIM_W'(MAX_DIM);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BIAS:      bias_q      <= pwdata[BIAS_W-1:0];
        REG_EMBED_DIM: embed_dim_q <= pwdata[DIM_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BIAS:      prdata = DATA_W'(bias_q);
      REG_EMBED_DIM: prdata = DATA_W'(embed_dim_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage advance: each stage loads when empty or when its successor loads
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, ov_q;
  logic ld1, ld2, ld3, ld_out;

  assign ld_out     = !ov_q || out_ready_i;
  assign ld3        = !v3_q || ld_out;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_ready_o = ld1;

  logic acc_in, take_sample, take_load;
  assign acc_in      = in_valid_i && in_ready_o;
  assign take_sample = acc_in && (action_e'(action_i) == ACT_SAMPLE);
  assign take_load   = acc_in && (action_e'(action_i) == ACT_LOAD);

  // ---------------------------------------------------------------------------
  // Sentence counters and decisions made at acceptance
  // ---------------------------------------------------------------------------
  logic [ELEM_W-1:0] elem_q, elem_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [SLOT_W-1:0] head_q, head_d, fill_q, fill_d;
  logic [DIM_W-1:0]  dim_eff;
  logic              row_done;
  ctrl_t             ctrl0;

  always_comb begin
    // clamp row length into 1..MAX_DIM
    if (embed_dim_q == '0) begin
      dim_eff = DIM_W'(1);
    end else if (embed_dim_q > DIM_W'(MAX_DIM)) begin
      dim_eff = DIM_W'(MAX_DIM);
    end else begin
      dim_eff = embed_dim_q;
    end

    row_done   = sentence_end_i || ((DIM_W'(elem_q) + DIM_W'(1)) >= dim_eff);
    // release an output only at the end of a row
    ctrl0.emit = sentence_end_i || (row_done && (fill_q == SLOT_W'(TAPS - 1)));
    ctrl0.last = sentence_end_i;
    ctrl0.head = head_q;
    ctrl0.fill = fill_q;
    if (fill_q == SLOT_W'(TAPS - 1)) begin
      ctrl0.idx = IDX_W'(row_q - ROW_W'(TAPS - 1));
    end else begin
      ctrl0.idx = '0;
    end

    elem_d = elem_q;
    row_d  = row_q;
    head_d = head_q;
    fill_d = fill_q;
    priority if (!row_done) begin
      elem_d = elem_q + ELEM_W'(1);
    end else if (sentence_end_i) begin
      elem_d = '0;
      row_d  = '0;
      head_d = '0;
      fill_d = '0;
    end else begin
      elem_d = '0;
      row_d  = (row_q == ROW_W'(MAX_ROWS - 1)) ? '0 : row_q + ROW_W'(1);
      head_d = (head_q == SLOT_W'(TAPS - 1)) ? '0 : head_q + SLOT_W'(1);
      if (fill_q != SLOT_W'(TAPS - 1)) begin
        fill_d = fill_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= '0;
      row_q  <= '0;
      head_q <= '0;
      fill_q <= '0;
    end else if (take_sample) begin
      elem_q <= elem_d;
      row_q  <= row_d;
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Weight store: write on load beats, read all taps at the current element
  // ---------------------------------------------------------------------------
  wr_t   wr;
  wvec_t w1;

  always_comb begin
    wr.en   = take_load && (32'(weight_tap_i) < TAPS) && (32'(weight_elem_i) < MAX_DIM);
    wr.bank = SLOT_W'(weight_tap_i);
    wr.addr = ELEM_W'(weight_elem_i);
    wr.data = value_i;
  end

  c1dtf_wmem u_wmem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (ld1),
    .rd_addr_i (elem_q),
    .rd_data_o (w1)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: element and control beside the weights read
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] x1_q;
  ctrl_t                   c1_q;

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      x1_q <= value_i;
      c1_q <= ctrl0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: one product per tap
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_d [TAPS];
  logic signed [PROD_W-1:0] prod_q [TAPS];
  ctrl_t                    c2_q;

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      prod_d[k] = x1_q * $signed(w1[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      prod_q <= prod_d;
      c2_q   <= c1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulate: each ring slot takes the product of the tap that feeds it
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc_q [TAPS];
  logic signed [ACC_W-1:0] acc_d [TAPS];
  logic signed [ACC_W-1:0] acc_new [TAPS];
  logic signed [ACC_W-1:0] sum_d;
  logic [SLOT_W-1:0]       emit_slot;
  logic [SLOT_W-1:0]       tap_of [TAPS];

  always_comb begin
    emit_slot = ring_slot(c2_q.head, c2_q.fill);
    for (int s = 0; s < TAPS; s++) begin
      tap_of[s] = ring_slot(c2_q.head, SLOT_W'(s));
      if (tap_of[s] <= c2_q.fill) begin
        acc_new[s] = acc_q[s] + ACC_W'(prod_q[tap_of[s]]);
      end else begin
        acc_new[s] = acc_q[s];
      end
      // clear the emitted slot, or every slot at sentence end
      if (c2_q.last || (c2_q.emit && (emit_slot == SLOT_W'(s)))) begin
        acc_d[s] = '0;
      end else begin
        acc_d[s] = acc_new[s];
      end
    end
    sum_d = acc_new[emit_slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TAPS; s++) begin
        acc_q[s] <= '0;
      end
    end else if (v2_q && ld3) begin
      acc_q <= acc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: emitted sum waiting for scaling
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] sum3_q;
  logic [IDX_W-1:0]        idx3_q;
  logic                    last3_q;

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      sum3_q  <= sum_d;
      idx3_q  <= c2_q.idx;
      last3_q <= c2_q.last;
    end
  end

  // Floor shift back to Q.12, add bias, saturate to 32 bits
  localparam int unsigned SH_W  = ACC_W - FRAC;
  localparam int unsigned SUM_W = SH_W + 1;
  logic signed [SUM_W-1:0] biased;
  logic signed [OUT_W-1:0] sat;

  always_comb begin
    biased = SUM_W'($signed(sum3_q[ACC_W-1:FRAC])) + SUM_W'(bias_q);
    if (biased > SUM_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}))) begin
      sat = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (biased < SUM_W'(signed'({1'b1, {(OUT_W-1){1'b0}}}))) begin
      sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat = OUT_W'(biased);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [OUT_W-1:0] out_value_q;
  logic [IDX_W-1:0]        out_index_q;
  logic                    last_q;

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      out_value_q <= sat;
      out_index_q <= idx3_q;
      last_q      <= last3_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_value_o = out_value_q;
  assign out_index_o = out_index_q;
  assign last_o      = last_q;

  // ---------------------------------------------------------------------------
  // Stage valids; only emitting items go past accumulation
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (ld1)    v1_q <= take_sample;
      if (ld2)    v2_q <= v1_q;
      if (ld3)    v3_q <= v2_q && c2_q.emit;
      if (ld_out) ov_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_head_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != SLOT_W'(TAPS - 1)) |-> (head_q == fill_q))
    else $error("ring head out of step with row fill");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_sample && sentence_end_i) |=>
      (elem_q == '0 && row_q == '0 && head_q == '0 && fill_q == '0))
    else $error("sentence counters not cleared after sentence end");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && ov_q && !out_ready_i))
    else $error("input stalled while the pipeline has room");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(v3_q))
    else $error("result appeared without an emitting item");

endmodule

`default_nettype wire
